>>> src/multi_slot_timeout_manager_top_defines.svh
// ----------------------------------------------------------------------------
// multi_slot_timeout_manager_top_defines
// assertion macros used by the timeout manager top module
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_TIMEOUT_MANAGER_TOP_DEFINES_SVH
`define MULTI_SLOT_TIMEOUT_MANAGER_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define MSTM_ASSERT_IMPL(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define MSTM_ASSERT_NEXT(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) \
		else $error(msg);

`endif

>>> src/mstm_pkg.sv
// ----------------------------------------------------------------------------
// mstm_pkg
// shared types and constants of the timeout manager
// ----------------------------------------------------------------------------
package mstm_pkg;
	localparam int SLOTS = 8;
	localparam int SLOT_W = 3;

	localparam logic [3:0] OP_TICK    = 4'd0;
	localparam logic [3:0] OP_ALLOC   = 4'd1;
	localparam logic [3:0] OP_FREE    = 4'd2;
	localparam logic [3:0] OP_START   = 4'd3;
	localparam logic [3:0] OP_RESTART = 4'd4;
	localparam logic [3:0] OP_STOP    = 4'd5;
	localparam logic [3:0] OP_RETRY   = 4'd6;
	localparam logic [3:0] OP_UPDATE  = 4'd7;
	localparam logic [3:0] OP_ACTIVE  = 4'd8;
	localparam logic [3:0] OP_QUERY   = 4'd9;
	localparam logic [3:0] OP_TOTALS  = 4'd10;

	localparam logic [1:0] MODE_OFF     = 2'd0;
	localparam logic [1:0] MODE_ACTIVE  = 2'd1;
	localparam logic [1:0] MODE_WARN    = 2'd2;
	localparam logic [1:0] MODE_EXPIRED = 2'd3;

	localparam logic [31:0] ACT_WINDOW   = 32'd100;
	localparam logic [31:0] IDLE_DEFAULT = 32'd1000;
	localparam logic [0:0]  REG_MAX_IDLE = 1'b0;

	// per-slot record as stored in the slot table
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] limit;
		logic [31:0] warn;
		logic [7:0]  rlim;
		logic [7:0]  retries;
		logic [1:0]  mode;
		logic        en;
		logic        warned;
		logic        auto_rs;
	} slot_rec_t;

	// verdict of the shared slot evaluator
	typedef struct packed {
		logic [31:0] elapsed;
		logic        reached;
		logic        warn_fire;
		logic [31:0] remaining;
		logic        may_retry;
	} slot_eval_t;
endpackage

>>> src/multi_slot_timeout_manager_top.sv
// ----------------------------------------------------------------------------
// multi_slot_timeout_manager_top
// eight-slot millisecond timeout table with a scanning update sequencer
// ----------------------------------------------------------------------------
// usage:
//   in channel (valid/ready) carries one op word with slot and allocate data
//   out channel (valid/ready) returns exactly one result word per op word
//   apb port holds the idle limit of the responsive flag at address 0
//   (reset value 1000)
// sequencing:
//   single-slot ops (tick, free, start, restart, stop, retry, activity,
//   query) go from idle straight to the done state, which loads the result
//   allocate, update and totals first walk the slots through the one shared
//   evaluator in the scan state, one slot a cycle, then form the result
//   a word is accepted only when the block is idle and the output register
//   is empty, so a new word may follow the cycle after its result is taken
// reset:
//   every slot disabled, time and totals zero, no result pending
// stall:
//   a held result stays in the output register and in_ready stays low
// ----------------------------------------------------------------------------
`include "multi_slot_timeout_manager_top_defines.svh"

module multi_slot_timeout_manager_top import mstm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  op,
	input  logic [2:0]  slot,
	input  logic [31:0] limit_ms,
	input  logic [31:0] warn_ms,
	input  logic [7:0]  retry_limit,
	input  logic        auto_restart,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [2:0]  slot_id,
	output logic [1:0]  slot_state,
	output logic [31:0] elapsed_ms,
	output logic [31:0] remaining_ms,
	output logic        may_retry,
	output logic [3:0]  expired_found,
	output logic [3:0]  warned_found,
	output logic [31:0] total_expiries,
	output logic [31:0] total_warnings_seen,
	output logic        responsive,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]  state_q;
	logic [SLOT_W-1:0] idx_q;
	logic [3:0]  op_q;
	logic [2:0]  slot_q;
	logic [31:0] lim_q, warn_q;
	logic [7:0]  rlim_q;
	logic        auto_q;
	logic        found_q;
	logic [2:0]  fid_q;
	logic [3:0]  ne_q, nw_q;

	logic [31:0] max_idle_q, now_q, last_act_q, exp_tot_q, warn_tot_q;
	slot_rec_t   tab_q [SLOTS];

	logic        ov_q;
	logic        ok_q, mr_q;
	logic [2:0]  sid_q;
	logic [1:0]  sst_q;
	logic [31:0] el_q, rem_q;
	logic [3:0]  ef_q, wf_q;

	logic        accept, out_take, recent;
	logic [SLOT_W-1:0] eidx;
	slot_rec_t   erec, nrec;
	slot_eval_t  ev;

	assign in_ready = (state_q == ST_IDLE) && !ov_q;
	assign accept   = in_valid && in_ready;
	assign out_take = ov_q && out_ready;
	assign recent   = (now_q - last_act_q) < ACT_WINDOW;

	// the evaluator looks at the scanned slot or at the addressed slot
	assign eidx = (state_q == ST_SCAN) ? idx_q : slot_q;
	assign erec = tab_q[eidx];

	mstm_eval u_eval (.now_ms(now_q), .rec(erec), .res(ev));

	// apb: single register, zero wait
	assign pready = 1'b1;
	assign prdata = (paddr[1:0] == {REG_MAX_IDLE, 1'b0}) ? max_idle_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_idle_q <= IDLE_DEFAULT;
		else if (psel && penable && pwrite && paddr == {REG_MAX_IDLE, 1'b0})
			max_idle_q <= pwdata;
	end

	// update step for one slot during a scan
	always_comb begin
		nrec = erec;
		if (erec.mode != MODE_OFF) begin
			if (erec.en && ev.reached)
				nrec.mode = MODE_EXPIRED;
			else if (erec.en && ev.warn_fire) begin
				nrec.warned = 1'b1;
				nrec.mode   = MODE_WARN;
			end
			if (erec.auto_rs && recent) begin
				nrec.start  = now_q;
				nrec.mode   = MODE_ACTIVE;
				nrec.en     = 1'b1;
				nrec.warned = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			now_q      <= '0;
			last_act_q <= '0;
			exp_tot_q  <= '0;
			warn_tot_q <= '0;
			ov_q       <= 1'b0;
			found_q    <= 1'b0;
			fid_q      <= '0;
			ne_q       <= '0;
			nw_q       <= '0;
			for (int i = 0; i < SLOTS; i++) tab_q[i] <= '0;
		end else begin
			if (out_take) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= op;
						slot_q  <= slot;
						lim_q   <= limit_ms;
						warn_q  <= warn_ms;
						rlim_q  <= retry_limit;
						auto_q  <= auto_restart;
						idx_q   <= '0;
						found_q <= 1'b0;
						fid_q   <= '0;
						ne_q    <= '0;
						nw_q    <= '0;
						if (op == OP_ALLOC || op == OP_UPDATE || op == OP_TOTALS)
							state_q <= ST_SCAN;
						else
							state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					case (op_q)
						OP_ALLOC: begin
							if (!found_q && erec.mode == MODE_OFF) begin
								found_q <= 1'b1;
								fid_q   <= idx_q;
							end
						end
						OP_UPDATE: begin
							tab_q[idx_q] <= nrec;
							if (erec.mode != MODE_OFF && erec.en && ev.reached) begin
								if (ne_q != 4'd15) ne_q <= ne_q + 4'd1;
								exp_tot_q <= exp_tot_q + 32'd1;
							end else if (erec.mode != MODE_OFF && erec.en && ev.warn_fire)
								begin
								if (nw_q != 4'd15) nw_q <= nw_q + 4'd1;
								warn_tot_q <= warn_tot_q + 32'd1;
							end
						end
						default: begin
							if (erec.mode == MODE_EXPIRED && ne_q != 4'd15)
								ne_q <= ne_q + 4'd1;
							else if (erec.mode == MODE_WARN && nw_q != 4'd15)
								nw_q <= nw_q + 4'd1;
						end
					endcase
					if (idx_q == SLOT_W'(SLOTS - 1))
						state_q <= ST_DONE;
					else
						idx_q <= idx_q + SLOT_W'(1);
				end
				ST_DONE: begin
					ok_q  <= 1'b0;
					sid_q <= '0;
					sst_q <= MODE_OFF;
					el_q  <= '0;
					rem_q <= '0;
					mr_q  <= 1'b0;
					ef_q  <= '0;
					wf_q  <= '0;
					case (op_q)
						OP_TICK: begin
							now_q <= now_q + 32'd1;
							ok_q  <= 1'b1;
						end
						OP_ALLOC: begin
							if (found_q) begin
								tab_q[fid_q] <= '{start: now_q, limit: lim_q,
									warn: warn_q, rlim: rlim_q, retries: 8'd0,
									mode: MODE_ACTIVE, en: 1'b1, warned: 1'b0,
									auto_rs: auto_q};
								ok_q  <= 1'b1;
								sid_q <= fid_q;
							end
						end
						OP_FREE: begin
							if (erec.mode != MODE_OFF) begin
								tab_q[slot_q] <= '0;
								ok_q <= 1'b1;
							end
						end
						OP_START, OP_RESTART: begin
							tab_q[slot_q].start  <= now_q;
							tab_q[slot_q].mode   <= MODE_ACTIVE;
							tab_q[slot_q].en     <= 1'b1;
							tab_q[slot_q].warned <= 1'b0;
							if (op_q == OP_START) tab_q[slot_q].retries <= 8'd0;
							ok_q <= 1'b1;
						end
						OP_STOP: begin
							tab_q[slot_q].en   <= 1'b0;
							tab_q[slot_q].mode <= MODE_OFF;
							ok_q <= 1'b1;
						end
						OP_RETRY: begin
							if (ev.may_retry) begin
								tab_q[slot_q].retries <= erec.retries + 8'd1;
								tab_q[slot_q].start   <= now_q;
								tab_q[slot_q].mode    <= MODE_ACTIVE;
								tab_q[slot_q].en      <= 1'b1;
								tab_q[slot_q].warned  <= 1'b0;
								ok_q <= 1'b1;
							end
						end
						OP_UPDATE, OP_TOTALS: begin
							ok_q <= 1'b1;
							ef_q <= ne_q;
							wf_q <= nw_q;
						end
						OP_ACTIVE: begin
							last_act_q <= now_q;
							ok_q <= 1'b1;
						end
						OP_QUERY: begin
							ok_q  <= 1'b1;
							sst_q <= erec.mode;
							mr_q  <= ev.may_retry;
							if (erec.en) begin
								el_q  <= ev.elapsed;
								rem_q <= ev.remaining;
							end
						end
						default: ;
					endcase
					ov_q    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid           = ov_q;
	assign ok                  = ok_q;
	assign slot_id             = sid_q;
	assign slot_state          = sst_q;
	assign elapsed_ms          = el_q;
	assign remaining_ms        = rem_q;
	assign may_retry           = mr_q;
	assign expired_found       = ef_q;
	assign warned_found        = wf_q;
	// totals are running counters that advance during update scans; responsive is combinational
	assign total_expiries      = exp_tot_q;
	assign total_warnings_seen = warn_tot_q;
	assign responsive          = (now_q - last_act_q) < max_idle_q;

	`MSTM_ASSERT_IMPL(a_ready_only_idle, in_ready, state_q == ST_IDLE && !ov_q,
		"ready outside idle")
	`MSTM_ASSERT_NEXT(a_done_gives_word, state_q == ST_DONE, ov_q && state_q == ST_IDLE,
		"done state did not load a result word")
	`MSTM_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != ST_IDLE,
		"accepted word left sequencer idle")
	`MSTM_ASSERT_IMPL(a_no_scan_with_word, state_q == ST_SCAN, !ov_q,
		"scan running while result pending")
endmodule

>>> src/mstm_eval.sv
// ----------------------------------------------------------------------------
// mstm_eval
// shared unit: elapsed time, limit and warning compare for one slot
// ----------------------------------------------------------------------------
module mstm_eval import mstm_pkg::*; (
	input  logic [31:0] now_ms,
	input  slot_rec_t   rec,
	output slot_eval_t  res
);
	logic [31:0] el;
	logic        reached;

	assign el      = now_ms - rec.start;
	assign reached = el >= rec.limit;

	always_comb begin
		res.elapsed   = el;
		res.reached   = reached;
		res.warn_fire = (rec.warn != 32'd0) && (el >= rec.warn) && !rec.warned;
		res.remaining = reached ? 32'd0 : rec.limit - el;
		res.may_retry = rec.retries < rec.rlim;
	end
endmodule
